// File: src/cisb_pkg.sv
// Shared types and constants for the interleaved sprite blit engine.
`timescale 1ns / 1ps

package cisb_pkg;

   localparam int ADDR_W = 14;
   localparam logic [ADDR_W:0] BANK_OFFSET = 15'h2000;
   localparam logic [6:0] LINE_PAIR_BYTES = 7'h50;

   typedef struct packed {
      logic       start_req;
      logic       erase;
      logic [8:0] pos_x;
      logic [7:0] pos_y;
      logic [8:0] width_px;
      logic [7:0] height_px;
      logic [7:0] sprite_byte;
   } item_type;

   typedef struct packed {
      logic [ADDR_W-1:0] video_address;
      logic [7:0]        video_byte;
      logic              last_write;
   } result_type;

endpackage

// File: src/cisb_in_stage.sv
// Input register that holds one accepted sprite byte until the engine takes it.
`timescale 1ns / 1ps

module cisb_in_stage
   import cisb_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     held_valid,
   output item_type held_item,
   input  logic     advance
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   assign in_ready   = !valid_ff || advance;
   assign held_valid = valid_ff;
   assign held_item  = item_ff;

   always_comb begin
      if (in_valid && in_ready) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         item_ff <= in_item;
      end
   end

endmodule

// File: src/cisb_engine.sv
// Sprite geometry state and the address computation for one byte.
`timescale 1ns / 1ps

module cisb_engine
   import cisb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  item_type   item,
   input  logic       advance,
   output logic       produce,
   output result_type result
);

   logic       active_ff, active_in;
   logic       erase_mode_ff, erase_mode_in;
   logic [6:0] column_base_ff, column_base_in;
   logic [7:0] row_bytes_ff, row_bytes_in;
   logic [7:0] rows_total_ff, rows_total_in;
   logic [8:0] scanline_ff, scanline_in;
   logic [7:0] row_index_ff, row_index_in;
   logic [6:0] column_index_ff, column_index_in;

   logic       act_eff;
   logic       erase_eff;
   logic [6:0] cb_eff;
   logic [7:0] rb_eff;
   logic [7:0] rt_eff;
   logic [8:0] sl_eff;
   logic [7:0] ri_eff;
   logic [6:0] ci_eff;
   logic [9:0] width_sum;
   logic [7:0] height_inc;
   logic [7:0] ci_next;
   logic [8:0] ri_next;
   logic [ADDR_W:0] line_offset;
   logic [ADDR_W:0] addr_sum;
   logic       row_done;
   logic       sprite_done;

   always_comb begin
      width_sum  = {1'b0, item.width_px} + 10'd4;
      height_inc = item.height_px + 8'd1;
      if (item.start_req) begin
         erase_eff = item.erase;
         cb_eff    = item.pos_x[8:2];
         rb_eff    = width_sum[9:2];
         rt_eff    = {height_inc[7:1], 1'b0};
         sl_eff    = {1'b0, item.pos_y};
         ri_eff    = 8'd0;
         ci_eff    = 7'd0;
         act_eff   = (rt_eff != 8'd0);
      end else begin
         erase_eff = erase_mode_ff;
         cb_eff    = column_base_ff;
         rb_eff    = row_bytes_ff;
         rt_eff    = rows_total_ff;
         sl_eff    = scanline_ff;
         ri_eff    = row_index_ff;
         ci_eff    = column_index_ff;
         act_eff   = active_ff;
      end
   end

   always_comb begin
      line_offset = {7'd0, sl_eff[8:1]} * {8'd0, LINE_PAIR_BYTES};
      addr_sum    = (sl_eff[0] ? BANK_OFFSET : '0) + line_offset
                    + {8'd0, cb_eff} + {8'd0, ci_eff};
      ci_next     = {1'b0, ci_eff} + 8'd1;
      ri_next     = {1'b0, ri_eff} + 9'd1;
      row_done    = (ci_next >= rb_eff);
      sprite_done = row_done && (ri_next >= {1'b0, rt_eff});
   end

   assign produce              = act_eff;
   assign result.video_address = addr_sum[ADDR_W-1:0];
   assign result.video_byte    = erase_eff ? 8'd0 : item.sprite_byte;
   assign result.last_write    = sprite_done;

   always_comb begin
      erase_mode_in   = erase_eff;
      column_base_in  = cb_eff;
      row_bytes_in    = rb_eff;
      rows_total_in   = rt_eff;
      scanline_in     = sl_eff;
      row_index_in    = ri_eff;
      column_index_in = ci_eff;
      active_in       = act_eff;
      if (act_eff) begin
         if (row_done) begin
            column_index_in = 7'd0;
            row_index_in    = ri_next[7:0];
            scanline_in     = sl_eff + 9'd1;
            if (sprite_done) begin
               active_in = 1'b0;
            end
         end else begin
            column_index_in = ci_next[6:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff       <= 1'b0;
         erase_mode_ff   <= 1'b0;
         column_base_ff  <= '0;
         row_bytes_ff    <= '0;
         rows_total_ff   <= '0;
         scanline_ff     <= '0;
         row_index_ff    <= '0;
         column_index_ff <= '0;
      end else if (advance) begin
         active_ff       <= active_in;
         erase_mode_ff   <= erase_mode_in;
         column_base_ff  <= column_base_in;
         row_bytes_ff    <= row_bytes_in;
         rows_total_ff   <= rows_total_in;
         scanline_ff     <= scanline_in;
         row_index_ff    <= row_index_in;
         column_index_ff <= column_index_in;
      end
   end

endmodule

// File: src/cisb_out_stage.sv
// Result register that holds one framebuffer write until it is taken.
`timescale 1ns / 1ps

module cisb_out_stage
   import cisb_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type load_result,
   output logic       can_load,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_result
);

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign can_load   = !valid_ff || out_ready;
   assign out_valid  = valid_ff;
   assign out_result = result_ff;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= load_result;
      end
   end

endmodule

// File: src/cga_interleaved_sprite_blit.sv
// Top level of the interleaved sprite blit engine.
// The engine takes one sprite byte per clock and returns at most one framebuffer
// write for it: the byte is held in the input register and the write in the result
// register, with the address formed by short logic in between. A byte that makes no
// write (no sprite active, past the end, or a start with no rows) still passes through
// the input register. The rate stays at one byte per clock as long as the result side
// takes each write when it is offered.
`timescale 1ns / 1ps

module cga_interleaved_sprite_blit
   import cisb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_start_req,
   input  logic              req_erase,
   input  logic [8:0]        req_pos_x,
   input  logic [7:0]        req_pos_y,
   input  logic [8:0]        req_width_px,
   input  logic [7:0]        req_height_px,
   input  logic [7:0]        req_sprite_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [ADDR_W-1:0] rsp_video_address,
   output logic [7:0]        rsp_video_byte,
   output logic              rsp_last_write
);

   item_type   req_item;
   item_type   held_item;
   logic       held_valid;
   logic       advance;
   logic       produce;
   logic       can_load;
   result_type engine_result;
   result_type out_result;

   assign req_item.start_req   = req_start_req;
   assign req_item.erase       = req_erase;
   assign req_item.pos_x       = req_pos_x;
   assign req_item.pos_y       = req_pos_y;
   assign req_item.width_px    = req_width_px;
   assign req_item.height_px   = req_height_px;
   assign req_item.sprite_byte = req_sprite_byte;

   assign advance = held_valid && (!produce || can_load);

   cisb_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_item    (req_item),
      .held_valid (held_valid),
      .held_item  (held_item),
      .advance    (advance)
   );

   cisb_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .item    (held_item),
      .advance (advance),
      .produce (produce),
      .result  (engine_result)
   );

   cisb_out_stage u_out_stage (
      .clock       (clock),
      .reset       (reset),
      .load        (advance && produce),
      .load_result (engine_result),
      .can_load    (can_load),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_result  (out_result)
   );

   assign rsp_video_address = out_result.video_address;
   assign rsp_video_byte    = out_result.video_byte;
   assign rsp_last_write    = out_result.last_write;

endmodule
